// File: rtl/cts_pkg.sv
package cts_pkg;

  // Register indexes on the configuration port
  localparam logic REG_STRIP_WIDTH  = 1'b0;
  localparam logic REG_PHASE_HALVES = 1'b1;

  // Fixed field widths
  localparam int CFG_W     = 11;
  localparam int SAMPLE_W  = 10;
  localparam int ROW_IN_W  = 4;
  localparam int COL_IN_W  = 10;
  localparam int TEXEL_W   = 8;
  // Half-column position divided by two: (sample + phase) >> 1
  localparam int DVD_W     = 11;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = 4;

  // Store address, sized for the largest strip (32 rows by 4096 columns)
  localparam int ADDR_W_MAX = 17;

  // Half-pixel radius and trig sample widths
  localparam int H_W    = 9;
  localparam int TRIG_W = 18;
  localparam int PROD_W = H_W + TRIG_W;
  localparam int POS_W  = 32;

  // Angle reduction and series constants
  localparam int       OPEN_GAP  = 16;
  localparam longint   Q28       = 64'sd268435456;
  localparam longint   Q24       = 64'sd16777216;
  localparam longint   PI_Q52    = 64'sh003243F6A8885A30;
  localparam longint   TWOPI_Q52 = 64'sh006487ED5110B461;
  localparam int       TERMS     = 14;

  // Front to back queue
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_t;

  // One classified request: a texel write or a render column
  typedef struct packed {
    op_t                   op;
    logic                  ok;
    logic [ADDR_W_MAX-1:0] addr;
    logic [SAMPLE_W-1:0]   sample;
    logic [TEXEL_W-1:0]    value;
  } entry_t;

endpackage

// File: rtl/circular_text_strip_plotter.sv
// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready  tdata: sample_index, texel_row, texel_column,
//                                     texel_value; tuser: operation
// out_      out  out_tvalid/out_tready tdata: pixel_x, pixel_y, pixel_color;
//                                     tuser: visible; tlast: last
// cfg_      in   cfg_we               index 0 column count, 1 phase_halves
//
// A load request goes from the front's idle state to its push state; it gives no result.
// A render request runs the front divider (one remainder bit per cycle for the column),
// then one row per cycle through the strip RAM read port while output is not stalled.
// The row sequencer pops no new request until the last row of the current one is issued.
// Reset (rst_n low, synchronous) clears control state only; the strip has no clearing.
// Output stalls freeze the back pipeline; the two-entry queue lets the front keep going.
module circular_text_strip_plotter #(
  parameter int MAX_STRIP_WIDTH = 1024,
  parameter int GLYPH_ROWS      = 16,
  parameter int SAMPLE_COUNT    = 822,
  parameter int RING_RADIUS     = 68,
  parameter int SCREEN_WIDTH    = 320,
  parameter int SCREEN_HEIGHT   = 200
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [cts_pkg::CFG_W-1:0] cfg_wdata,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [9:0] sample_index, [13:10] texel_row, [23:14] texel_column, [31:24] texel_value
  input  logic [31:0]               in_tdata,
  // [0] operation
  input  logic                      in_tuser,
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [8:0] pixel_x, [16:9] pixel_y, [24:17] pixel_color, [31:25] zero
  output logic [31:0]               out_tdata,
  // [0] visible
  output logic                      out_tuser,
  output logic                      out_tlast
);
  import cts_pkg::*;

  logic   push, full, pop, empty;
  entry_t push_data, pop_data;
  logic [8:0]         px;
  logic [7:0]         py;
  logic [TEXEL_W-1:0] pcolor;

  cts_front #(
    .MAX_STRIP_WIDTH (MAX_STRIP_WIDTH),
    .GLYPH_ROWS      (GLYPH_ROWS),
    .SAMPLE_COUNT    (SAMPLE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_sample (in_tdata[9:0]),
    .in_row    (in_tdata[13:10]),
    .in_col    (in_tdata[23:14]),
    .in_value  (in_tdata[31:24]),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  cts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  cts_back #(
    .MAX_STRIP_WIDTH (MAX_STRIP_WIDTH),
    .GLYPH_ROWS      (GLYPH_ROWS),
    .SAMPLE_COUNT    (SAMPLE_COUNT),
    .RING_RADIUS     (RING_RADIUS),
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (px),
    .out_y     (py),
    .out_color (pcolor),
    .out_vis   (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'b0, pcolor, py, px};

endmodule

// File: rtl/cts_ram.sv
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/cts_queue.sv
module cts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cts_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output cts_pkg::entry_t pop_data,
  output logic            empty
);
  import cts_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  // Front must hold its request while the queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

// File: rtl/cts_front.sv
module cts_front #(
  parameter int MAX_STRIP_WIDTH = 1024,
  parameter int GLYPH_ROWS      = 16,
  parameter int SAMPLE_COUNT    = 822
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration writes
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [cts_pkg::CFG_W-1:0]    cfg_wdata,
  // input request
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [cts_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [cts_pkg::ROW_IN_W-1:0] in_row,
  input  logic [cts_pkg::COL_IN_W-1:0] in_col,
  input  logic [cts_pkg::TEXEL_W-1:0]  in_value,
  // queue side
  output logic                         push,
  output cts_pkg::entry_t              push_data,
  input  logic                         full
);
  import cts_pkg::*;

  front_state_t         state_r, state_nxt;
  entry_t               ent_r, ent_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [DVD_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0]     width_r, phase_r;
  logic [CFG_W-1:0]     width_eff;
  logic [DVD_W:0]       trial;
  logic [DVD_W:0]       sum;
  logic                 accept;
  logic                 div_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CFG_W'(1024);
      phase_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRIP_WIDTH:  width_r <= cfg_wdata;
        REG_PHASE_HALVES: phase_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Zero acts as one, anything above the strip acts as the strip
  always_comb begin
    if (width_r == '0) begin
      width_eff = CFG_W'(1);
    end else if (int'(width_r) > MAX_STRIP_WIDTH) begin
      width_eff = CFG_W'(MAX_STRIP_WIDTH);
    end else begin
      width_eff = width_r;
    end
  end

  assign accept   = in_valid && in_ready;
  assign div_done = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sum      = {2'b00, in_sample} + {1'b0, phase_r};

  // One restoring remainder step per cycle
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    if (trial >= {1'b0, width_eff}) begin
      trial = trial - {1'b0, width_eff};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: begin
        if (accept) begin
          state_nxt = (op_t'(in_op) == OP_RENDER) ? FS_DIV : FS_PUSH;
        end
      end
      FS_DIV: begin
        if (div_done) begin
          state_nxt = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!push_data.ok && push_data.op == OP_LOAD) begin
          state_nxt = FS_IDLE;
        end else if (!full) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    unique case (state_r)
      FS_IDLE: in_ready = 1'b1;
      FS_DIV:  ;
      FS_PUSH: push = !full && (ent_r.op == OP_RENDER || ent_r.ok);
      default: ;
    endcase
  end

  assign push_data = ent_r;

  // Datapath next values
  always_comb begin
    ent_nxt = ent_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (state_r == FS_IDLE && accept) begin
      ent_nxt.op     = op_t'(in_op);
      ent_nxt.sample = in_sample;
      ent_nxt.value  = in_value;
      if (op_t'(in_op) == OP_LOAD) begin
        ent_nxt.ok   = (int'(in_row) < GLYPH_ROWS) && (int'(in_col) < MAX_STRIP_WIDTH);
        ent_nxt.addr = ADDR_W_MAX'(int'(in_row) * MAX_STRIP_WIDTH + int'(in_col));
      end else begin
        ent_nxt.ok   = (int'(in_sample) < SAMPLE_COUNT);
        ent_nxt.addr = '0;
      end
      dvd_nxt = sum[DVD_W:1];
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (state_r == FS_DIV) begin
      rem_nxt = trial[DVD_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (div_done) begin
        ent_nxt.addr = ADDR_W_MAX'(trial[DVD_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// File: rtl/cts_back.sv
module cts_back #(
  parameter int MAX_STRIP_WIDTH = 1024,
  parameter int GLYPH_ROWS      = 16,
  parameter int SAMPLE_COUNT    = 822,
  parameter int RING_RADIUS     = 68,
  parameter int SCREEN_WIDTH    = 320,
  parameter int SCREEN_HEIGHT   = 200
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // queue side
  output logic                        pop,
  input  cts_pkg::entry_t             pop_data,
  input  logic                        empty,
  // result stream
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [8:0]                  out_x,
  output logic [7:0]                  out_y,
  output logic [cts_pkg::TEXEL_W-1:0] out_color,
  output logic                        out_vis,
  output logic                        out_last
);
  import cts_pkg::*;

  localparam int DEPTH = GLYPH_ROWS * MAX_STRIP_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int TW    = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int H0    = 2 * RING_RADIUS + GLYPH_ROWS - 1;
  localparam int D     = 2 * RING_RADIUS;
  localparam int CX    = SCREEN_WIDTH / 2;
  localparam int CY    = SCREEN_HEIGHT / 2;

  typedef logic [2*TRIG_W-1:0] trig_tab_t [SAMPLE_COUNT];
  typedef longint series_div_t [1:TERMS];

  // Taylor term divisors: (2j)(2j+1) for sine, (2j-1)(2j) for cosine
  function automatic series_div_t series_divs(input bit odd);
    series_div_t dv;
    for (int j = 1; j <= TERMS; j++) begin
      dv[j] = odd ? longint'((2 * j) * (2 * j + 1)) : longint'((2 * j - 1) * (2 * j));
    end
    return dv;
  endfunction

  localparam series_div_t SIN_DIV = series_divs(1'b1);
  localparam series_div_t COS_DIV = series_divs(1'b0);

  function automatic longint to_q16(longint v);
    if (v >= 0) begin
      return (v + 2048) / 4096;
    end
    return -((-v + 2048) / 4096);
  endfunction

  // Sine and cosine per sample, worked out at elaboration
  function automatic trig_tab_t build_tab();
    trig_tab_t       tab;
    longint unsigned n, q, r, t52u;
    longint          t52, a, a2, st, ss, ct, cc;
    logic [TRIG_W-1:0] cxv, syv;
    for (int k = 0; k < SAMPLE_COUNT; k++) begin
      n    = longint'(k + OPEN_GAP);
      q    = n / D;
      r    = n % D;
      t52u = (q << 52) + ((r << 52) / D);
      t52  = longint'(t52u % TWOPI_Q52);
      if (t52 > PI_Q52) begin
        t52 = t52 - TWOPI_Q52;
      end
      a  = t52 / Q24;
      a2 = a * a / Q28;
      st = a;
      ss = a;
      ct = Q28;
      cc = Q28;
      for (int j = 1; j <= TERMS; j++) begin
        st = -(st * a2 / Q28) / SIN_DIV[j];
        ss = ss + st;
        ct = -(ct * a2 / Q28) / COS_DIV[j];
        cc = cc + ct;
      end
      cxv    = TRIG_W'(to_q16(-ss));
      syv    = TRIG_W'(to_q16(cc));
      tab[k] = {syv, cxv};
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_tab();

  // Half away from zero, then divide by 2^17
  function automatic logic signed [POS_W-1:0] round_pos(logic signed [POS_W-1:0] num);
    if (num >= 0) begin
      return (num + 32'sd65536) >>> 17;
    end
    return -((-num + 32'sd65536) >>> 17);
  endfunction

  logic                     busy_r;
  logic [RW-1:0]            row_r;
  logic [AW-1:0]            addr_r;
  logic                     ok_r;
  logic signed [TRIG_W-1:0] cx_r, sy_r;
  logic [TW-1:0]            tab_idx;
  logic                     en;
  logic                     issue;
  logic                     row_last;
  logic signed [H_W-1:0]    h;

  logic                     s1_v_r, s1_ok_r, s1_last_r;
  logic signed [PROD_W-1:0] s1_px_r, s1_py_r;

  logic                     out_valid_r;
  logic [8:0]               out_x_r;
  logic [7:0]               out_y_r;
  logic [TEXEL_W-1:0]       out_color_r;
  logic                     out_vis_r, out_last_r;

  logic [TEXEL_W-1:0]       ram_rdata;
  logic                     ram_we;
  logic signed [POS_W-1:0]  xs, ys;
  logic [TEXEL_W-1:0]       tex;
  logic                     vis;

  // Pipeline advances whenever the output register is free or drained
  assign en       = !out_valid_r || out_ready;
  assign issue    = busy_r && en;
  assign row_last = (row_r == RW'(GLYPH_ROWS - 1));
  assign pop      = !empty && !busy_r;
  assign ram_we   = pop && pop_data.op == OP_LOAD && pop_data.ok;
  assign tab_idx  = pop_data.ok ? TW'(pop_data.sample) : '0;
  assign h        = H_W'(H0 - 2 * int'(row_r));

  cts_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (DEPTH)
  ) u_strip (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(pop_data.addr)),
    .wdata (pop_data.value),
    .re    (issue),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // Row sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (pop && pop_data.op == OP_RENDER) begin
      busy_r <= 1'b1;
    end else if (issue && row_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_data.op == OP_RENDER) begin
      row_r  <= '0;
      addr_r <= AW'(pop_data.addr);
      ok_r   <= pop_data.ok;
      cx_r   <= TRIG_TAB[tab_idx][TRIG_W-1:0];
      sy_r   <= TRIG_TAB[tab_idx][2*TRIG_W-1:TRIG_W];
    end else if (issue) begin
      row_r  <= row_r + 1'b1;
      addr_r <= addr_r + AW'(MAX_STRIP_WIDTH);
    end
  end

  // Stage 1: texel read and radius products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok_r   <= ok_r;
      s1_last_r <= row_last;
      s1_px_r   <= h * cx_r;
      s1_py_r   <= h * sy_r;
    end
  end

  // Stage 2: rounding and screen clip
  always_comb begin
    xs  = round_pos((32'sd1 <<< 17) * CX + POS_W'(s1_px_r));
    ys  = round_pos((32'sd1 <<< 17) * CY + POS_W'(s1_py_r));
    tex = s1_ok_r ? ram_rdata : '0;
    vis = s1_ok_r && (tex != '0) && (xs >= 0) && (xs < SCREEN_WIDTH) &&
          (ys >= 0) && (ys < SCREEN_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r     <= vis ? xs[8:0] : '0;
      out_y_r     <= vis ? ys[7:0] : '0;
      out_color_r <= tex;
      out_vis_r   <= vis;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_color = out_color_r;
  assign out_vis   = out_vis_r;
  assign out_last  = out_last_r;

`ifndef ASSERT_OFF
  // Skipped pixels carry no position
  a_invis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vis_r) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("invisible pixel with position");

  // A stalled stage-1 row is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !en) |=> s1_v_r)
    else $error("stage 1 row dropped during stall");

  // Row counter stays inside the strip
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (int'(row_r) < GLYPH_ROWS))
    else $error("row counter past last row");
`endif

endmodule
